// ===== hw/rtl/ufwc_pkg.sv =====
// ----------------------------------------------------------------------------
// ufwc_pkg
// Shared types and constants for the disjoint-set forest unit.
// ----------------------------------------------------------------------------
package ufwc_pkg;

  localparam int IN_W   = 10;
  localparam int SIZE_W = 11;

  localparam logic [SIZE_W-1:0] SIZE_CAP = 11'd1024;
  localparam logic [SIZE_W-1:0] SIZE_ONE = 11'd1;

  typedef enum logic [1:0] {
    ACT_MAKE  = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_UNION = 2'd2,
    ACT_FIND  = 2'd3
  } action_t;

  typedef enum logic [11:0] {
    S_CLEAR      = 12'b0000_0000_0001,
    S_IDLE       = 12'b0000_0000_0010,
    S_WRAP       = 12'b0000_0000_0100,
    S_START      = 12'b0000_0000_1000,
    S_ADD_CHK    = 12'b0000_0001_0000,
    S_UN_B       = 12'b0000_0010_0000,
    S_UN_CHK     = 12'b0000_0100_0000,
    S_WR2        = 12'b0000_1000_0000,
    S_WALK       = 12'b0001_0000_0000,
    S_COMP_ISSUE = 12'b0010_0000_0000,
    S_COMP       = 12'b0100_0000_0000,
    S_EMIT       = 12'b1000_0000_0000
  } state_t;

endpackage

// ===== hw/rtl/ufwc_ram.sv =====
// ----------------------------------------------------------------------------
// ufwc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ufwc_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/union_find_weighted_collapsing_unit.sv =====
// ----------------------------------------------------------------------------
// union_find_weighted_collapsing_unit
// Disjoint-set forest with union by size and path compression. The parent
// table sits in one RAM; a sequencer reads, modifies and writes it back.
//
//   channel  direction  handshake                    payload
//   item     in         item_valid / item_ready      action, first_index, second_index
//   result   out        result_valid / result_ready  root_index, set_size
//
// a failed add or union writes nothing and walks from an index to its root instead
// a table smaller than 1024 reduces both indices modulo TABLE_SIZE in a wrap state per item
// after reset a clearing pass writes every entry; no items are taken meanwhile
// one item at a time, through the single RAM port pair with its registered read
// a stalled result holds in the output register while the next item runs
// ----------------------------------------------------------------------------
module union_find_weighted_collapsing_unit
  import ufwc_pkg::*;
#(
  parameter int TABLE_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  action,
  input  logic [9:0]  first_index,
  input  logic [9:0]  second_index,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [9:0]  root_index,
  output logic [10:0] set_size
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int PAY_W = (IDX_W > SIZE_W) ? IDX_W : SIZE_W;
  localparam int ENT_W = PAY_W + 1;
  localparam bit NEED_WRAP = (TABLE_SIZE < (1 << IN_W));
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  state_t state, state_next;
  action_t op, op_next;

  logic [IN_W-1:0]   ra, ra_next, rb, rb_next;
  logic [2:0]        wstep, wstep_next;
  logic [IDX_W-1:0]  cur, cur_next;
  logic [IDX_W-1:0]  res_root, res_root_next;
  logic [SIZE_W-1:0] res_size, res_size_next;
  logic              root_a, root_a_next;
  logic [SIZE_W-1:0] size_a, size_a_next;
  logic [IDX_W-1:0]  wr2_addr, wr2_addr_next;
  logic [ENT_W-1:0]  wr2_ent, wr2_ent_next;
  logic              compress, compress_next;
  logic [IDX_W-1:0]  clr, clr_next;
  logic [IDX_W-1:0]  out_root;
  logic [SIZE_W-1:0] out_size;

  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [ENT_W-1:0]  wdata, rdata;

  logic              rd_root;
  logic [IDX_W-1:0]  rd_par;
  logic [SIZE_W-1:0] rd_size;
  logic [IDX_W-1:0]  idx_a, idx_b;
  logic [IN_W-1:0]   wa, wb;
  logic [IN_W+IDX_W-1:0] wide_a, wide_b;
  logic [IDX_W+9:0]  wide_root;

  function automatic logic [ENT_W-1:0] root_ent(input logic [SIZE_W-1:0] sz);
    return {1'b1, PAY_W'(sz)};
  endfunction

  function automatic logic [ENT_W-1:0] par_ent(input logic [IDX_W-1:0] p);
    return {1'b0, PAY_W'(p)};
  endfunction

  function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] x,
                                                input logic [SIZE_W-1:0] y);
    logic [SIZE_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return (s > {1'b0, SIZE_CAP}) ? SIZE_CAP : s[SIZE_W-1:0];
  endfunction

  ufwc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_root = rdata[PAY_W];
  assign rd_par  = rdata[IDX_W-1:0];
  assign rd_size = rdata[SIZE_W-1:0];

  assign wide_a = {{IDX_W{1'b0}}, ra};
  assign wide_b = {{IDX_W{1'b0}}, rb};
  assign idx_a  = wide_a[IDX_W-1:0];
  assign idx_b  = wide_b[IDX_W-1:0];

  // two restoring subtract steps of the modulo reduction per cycle
  always_comb begin
    logic [3:0]  k;
    logic [31:0] lim;
    wa = ra;
    wb = rb;
    for (int j = 0; j < 2; j++) begin
      k   = 4'd9 - {wstep, 1'b0} - 4'(j);
      lim = 32'(TABLE_SIZE) << k;
      if ({22'd0, wa} >= lim) begin
        wa = wa - lim[IN_W-1:0];
      end
      if ({22'd0, wb} >= lim) begin
        wb = wb - lim[IN_W-1:0];
      end
    end
  end

  always_comb begin
    state_next    = state;
    op_next       = op;
    ra_next       = ra;
    rb_next       = rb;
    wstep_next    = wstep;
    cur_next      = cur;
    res_root_next = res_root;
    res_size_next = res_size;
    root_a_next   = root_a;
    size_a_next   = size_a;
    wr2_addr_next = wr2_addr;
    wr2_ent_next  = wr2_ent;
    compress_next = compress;
    clr_next      = clr;
    we            = 1'b0;
    waddr         = cur;
    wdata         = par_ent(res_root);
    raddr         = cur;
    item_ready    = 1'b0;

    unique case (state)
      S_CLEAR: begin
        we       = 1'b1;
        waddr    = clr;
        wdata    = root_ent(SIZE_ONE);
        clr_next = clr + 1'b1;
        if (clr == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          op_next    = action_t'(action);
          ra_next    = first_index;
          rb_next    = second_index;
          wstep_next = '0;
          state_next = NEED_WRAP ? S_WRAP : S_START;
        end
      end
      S_WRAP: begin
        ra_next    = wa;
        rb_next    = wb;
        wstep_next = wstep + 1'b1;
        if (wstep == 3'd4) begin
          state_next = S_START;
        end
      end
      S_START: begin
        compress_next = 1'b0;
        unique case (op)
          ACT_MAKE: begin
            we            = 1'b1;
            waddr         = idx_a;
            wdata         = root_ent(SIZE_ONE);
            res_root_next = idx_a;
            res_size_next = SIZE_ONE;
            state_next    = S_EMIT;
          end
          ACT_ADD: begin
            raddr      = idx_b;
            state_next = S_ADD_CHK;
          end
          ACT_UNION: begin
            raddr      = idx_a;
            state_next = S_UN_B;
          end
          ACT_FIND: begin
            raddr         = idx_a;
            cur_next      = idx_a;
            compress_next = 1'b1;
            state_next    = S_WALK;
          end
          default: state_next = S_EMIT;
        endcase
      end
      S_ADD_CHK: begin
        if (rd_root && (idx_a != idx_b)) begin
          we            = 1'b1;
          waddr         = idx_a;
          wdata         = par_ent(idx_b);
          res_root_next = idx_b;
          res_size_next = sat_add(rd_size, SIZE_ONE);
          wr2_addr_next = idx_b;
          wr2_ent_next  = root_ent(sat_add(rd_size, SIZE_ONE));
          state_next    = S_WR2;
        end else begin
          raddr      = idx_b;
          cur_next   = idx_b;
          state_next = S_WALK;
        end
      end
      S_UN_B: begin
        root_a_next = rd_root;
        size_a_next = rd_size;
        raddr       = idx_b;
        state_next  = S_UN_CHK;
      end
      S_UN_CHK: begin
        if (root_a && rd_root && (idx_a != idx_b)) begin
          we            = 1'b1;
          res_size_next = sat_add(size_a, rd_size);
          if (size_a > rd_size) begin
            waddr         = idx_a;
            wdata         = root_ent(sat_add(size_a, rd_size));
            res_root_next = idx_a;
            wr2_addr_next = idx_b;
            wr2_ent_next  = par_ent(idx_a);
          end else begin
            waddr         = idx_b;
            wdata         = root_ent(sat_add(size_a, rd_size));
            res_root_next = idx_b;
            wr2_addr_next = idx_a;
            wr2_ent_next  = par_ent(idx_b);
          end
          state_next = S_WR2;
        end else begin
          raddr      = idx_a;
          cur_next   = idx_a;
          state_next = S_WALK;
        end
      end
      S_WR2: begin
        we         = 1'b1;
        waddr      = wr2_addr;
        wdata      = wr2_ent;
        state_next = S_EMIT;
      end
      S_WALK: begin
        if (rd_root) begin
          res_root_next = cur;
          res_size_next = rd_size;
          state_next    = compress ? S_COMP_ISSUE : S_EMIT;
        end else begin
          cur_next = rd_par;
          raddr    = rd_par;
        end
      end
      S_COMP_ISSUE: begin
        raddr      = idx_a;
        cur_next   = idx_a;
        state_next = S_COMP;
      end
      S_COMP: begin
        if ((cur == res_root) || rd_root) begin
          state_next = S_EMIT;
        end else begin
          we       = 1'b1;
          waddr    = cur;
          wdata    = par_ent(res_root);
          cur_next = rd_par;
          raddr    = rd_par;
        end
      end
      S_EMIT: begin
        if (!result_valid || result_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      if (state == S_EMIT && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    ra       <= ra_next;
    rb       <= rb_next;
    wstep    <= wstep_next;
    cur      <= cur_next;
    res_root <= res_root_next;
    res_size <= res_size_next;
    root_a   <= root_a_next;
    size_a   <= size_a_next;
    wr2_addr <= wr2_addr_next;
    wr2_ent  <= wr2_ent_next;
    compress <= compress_next;
    if (state == S_EMIT && (!result_valid || result_ready)) begin
      out_root <= res_root;
      out_size <= res_size;
    end
  end

  assign wide_root  = {10'd0, out_root};
  assign root_index = wide_root[9:0];
  assign set_size   = out_size;

  // no table write while waiting for an item
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !we)
    else $error("table written while idle");

  // a delivered size is never zero and never above the cap
  a_size_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (set_size != 11'd0) && (set_size <= SIZE_CAP))
    else $error("result size out of range");

  // compression never overwrites the root itself
  a_comp_root: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMP) && we |-> waddr != res_root)
    else $error("root overwritten during compression");

  // reset always starts the clearing pass
  a_reset_clear: assert property (@(posedge clk)
    rst |=> state == S_CLEAR)
    else $error("clearing pass not started after reset");

endmodule
